[design/gfe_pkg.sv]
// ----------------------------------------------------------------------------
// gfe_pkg
// Shared types, constants and table helper for the Gaussian function evaluator.
// ----------------------------------------------------------------------------
package gfe_pkg;

	// field widths
	localparam int unsigned X_W      = 24;
	localparam int unsigned PEAK_W   = 20;
	localparam int unsigned INV_W    = 24;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned T_W      = 33;   // base-2 exponent, Q.16
	localparam int unsigned EXP_LIMIT = 32;
	localparam int unsigned N_W      = 5;    // integer part of the exponent below the limit

	// fixed-point constants (Q.30)
	localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
	localparam logic [63:0] LN2_Q30      = 64'd744261118;
	localparam int unsigned SERIES_TERMS = 24;

	// reset values of the registers
	localparam logic [PEAK_W-1:0] PEAK_RST = 20'd65536;
	localparam logic [X_W-1:0]    MEAN_RST = 24'd0;
	localparam logic [INV_W-1:0]  INV_RST  = 24'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_HEIGHT  = 2'd0,
		REG_CENTER_MEAN  = 2'd1,
		REG_INV_TWO_VAR  = 2'd2
	} cfg_reg_t;

	// side info that travels along with the mantissa
	typedef struct packed {
		logic           ovf;   // exponent past the limit
		logic [N_W-1:0] n;     // integer part of the exponent
	} exp_ctl_t;

	// 2^(-i/D) in Q.fb from z = ln2*i/D in Q.30, via a truncated Taylor series.
	// Used only at elaboration to build the fraction table.
	function automatic logic [63:0] pow2_entry(input logic [63:0] z, input int unsigned fb);
		logic [63:0] term;
		logic [63:0] sum;
		term = 64'd1 << 30;
		sum  = term;
		for (int unsigned k = 1; k <= SERIES_TERMS; k++) begin
			term = ((term * z) >> 30) / 64'(k);
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		return (sum + (64'd1 << (29 - fb))) >> (30 - fb);
	endfunction

endpackage

[design/gfe_exp2_interp.sv]
// ----------------------------------------------------------------------------
// gfe_exp2_interp
// Two pipeline stages: fraction table lookup of 2^(-f), then linear interpolation.
// ----------------------------------------------------------------------------
module gfe_exp2_interp import gfe_pkg::*; #(
	parameter int unsigned EXP_TABLE_DEPTH = 64,
	parameter int unsigned FRACTION_BITS   = 16
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [T_W-1:0]           t_in,
	output logic [FRACTION_BITS:0]   mant,
	output exp_ctl_t                 ctl
);

	localparam int unsigned E_W   = FRACTION_BITS + 1;
	localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int unsigned POS_W = 16 + IDX_W;

	// constant table, D+1 entries
	logic [E_W-1:0] exp_tab [0:EXP_TABLE_DEPTH];

	for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
		localparam logic [63:0] ZV = (LN2_Q30 * 64'(gi)) / EXP_TABLE_DEPTH;
		assign exp_tab[gi] = E_W'(pow2_entry(ZV, FRACTION_BITS));
	end

	// stage 5: split exponent, scale fraction, look up neighbors
	logic [POS_W-1:0] pos;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] idx_nxt;
	logic [E_W-1:0]   e0;
	logic [E_W-1:0]   e1;
	exp_ctl_t         ctl5;

	assign pos     = POS_W'(t_in[15:0]) * POS_W'(EXP_TABLE_DEPTH);
	assign idx     = pos[POS_W-1:16];
	assign idx_nxt = idx + IDX_W'(1);
	assign e0      = exp_tab[idx];
	assign e1      = exp_tab[idx_nxt];
	assign ctl5.ovf = |t_in[T_W-1:16+N_W];
	assign ctl5.n   = t_in[16+N_W-1:16];

	logic [E_W-1:0] e0_s5;
	logic [E_W-1:0] diff_s5;
	logic [15:0]    r_s5;
	exp_ctl_t       ctl_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			e0_s5   <= e0;
			diff_s5 <= e0 - e1;
			r_s5    <= pos[15:0];
			ctl_s5  <= ctl5;
		end
	end

	// stage 6: m = e0 - (diff*r) >> 16
	logic [E_W+15:0] step;
	logic [E_W-1:0]  m_s6;
	exp_ctl_t        ctl_s6;

	assign step = (E_W+16)'(diff_s5) * (E_W+16)'(r_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6   <= e0_s5 - step[E_W+15:16];
			ctl_s6 <= ctl_s5;
		end
	end

	assign mant = m_s6;
	assign ctl  = ctl_s6;

endmodule

[design/gaussian_function_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// gaussian_function_evaluator_unit
// Fixed-point height*exp(-(x-mean)^2*inv_two_variance), 1 req/cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes a signed Q8.16 sample per request and returns peak_height times
// exp(-(x - center_mean)^2 * inv_two_variance) in unsigned Q4.16. Software
// writes inv_two_variance = 1/(2 sigma^2) and, for a normalized curve,
// peak_height = 1/(sigma*sqrt(2 pi)); software must write registers only
// while the unit is empty; the unit does not enforce this. The exponential
// is 2^(-t) with t = arg*log2(e): the integer part of t is a right shift,
// the fraction goes through a table of 2^(-i/D) with linear interpolation.
// When the integer part reaches 32 the result is forced to zero and
// underflowed is set; a result that just truncates below one LSB reads zero
// with underflowed clear. The argument saturates at 2^32-1 before scaling.
// There are eight register stages: distance, square, scale, log2(e) multiply,
// table lookup, interpolation, height multiply and output register. The whole
// pipeline advances together and takes a new request every cycle; it halts
// only while a finished result sits in the output register under stall.
// ----------------------------------------------------------------------------
module gaussian_function_evaluator_unit import gfe_pkg::*; #(
	parameter int unsigned EXP_TABLE_DEPTH = 64,
	parameter int unsigned FRACTION_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config write port
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	// sample channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [X_W-1:0]       sample_x,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [PEAK_W-1:0]           curve_value,
	output logic                        underflowed
);

	localparam int unsigned E_W  = FRACTION_BITS + 1;
	localparam int unsigned PP_W = PEAK_W + E_W;
	localparam int unsigned SH_W = $clog2(FRACTION_BITS + EXP_LIMIT);

	// ---------------- configuration registers ----------------
	logic [PEAK_W-1:0]     peak_height_q;
	logic signed [X_W-1:0] center_mean_q;
	logic [INV_W-1:0]      inv_two_variance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_height_q      <= PEAK_RST;
			center_mean_q      <= MEAN_RST;
			inv_two_variance_q <= INV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PEAK_HEIGHT: peak_height_q      <= cfg_data[PEAK_W-1:0];
				REG_CENTER_MEAN: center_mean_q      <= signed'(cfg_data[X_W-1:0]);
				REG_INV_TWO_VAR: inv_two_variance_q <= cfg_data[INV_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// Single advance for all stages; only a held result at the output blocks it.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv;

	assign adv      = !(v_s8 && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ---------------- s1: distance |x - mean| ----------------
	logic signed [X_W:0] x_off;
	logic [X_W:0]        x_off_abs;
	logic [X_W:0]        ad_s1;

	assign x_off     = (X_W+1)'(sample_x) - (X_W+1)'(center_mean_q);
	assign x_off_abs = x_off[X_W] ? (~x_off + (X_W+1)'(1)) : x_off;

	always_ff @(posedge clk) begin
		if (adv)
			ad_s1 <= x_off_abs;
	end

	// ---------------- s2: square, Q.16 ----------------
	logic [2*X_W+1:0] sq_full;
	logic [32:0]      sq_s2;     // up to 2^32

	assign sq_full = (2*X_W+2)'(ad_s1) * (2*X_W+2)'(ad_s1);

	always_ff @(posedge clk) begin
		if (adv)
			sq_s2 <= sq_full[48:16];
	end

	// ---------------- s3: scale by 1/(2 sigma^2), saturate ----------------
	logic [56:0] arg_full;
	logic [31:0] arg_sat;
	logic [31:0] arg_s3;

	assign arg_full = 57'(sq_s2) * 57'(inv_two_variance_q);
	assign arg_sat  = (|arg_full[56:48]) ? 32'hFFFF_FFFF : arg_full[47:16];

	always_ff @(posedge clk) begin
		if (adv)
			arg_s3 <= arg_sat;
	end

	// ---------------- s4: t = arg * log2(e) ----------------
	logic [62:0]    t_full;
	logic [T_W-1:0] t_s4;

	assign t_full = 63'(arg_s3) * 63'(LOG2E_Q30);

	always_ff @(posedge clk) begin
		if (adv)
			t_s4 <= t_full[62:30];
	end

	// ---------------- s5, s6: 2^(-frac) by table + interpolation ----------------
	logic [E_W-1:0] m_s6;
	exp_ctl_t       ctl_s6;

	gfe_exp2_interp #(
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
		.FRACTION_BITS   (FRACTION_BITS)
	) u_exp2 (
		.clk   (clk),
		.adv   (adv),
		.t_in  (t_s4),
		.mant  (m_s6),
		.ctl   (ctl_s6)
	);

	// ---------------- s7: height * mantissa ----------------
	logic [PP_W-1:0] pp_s7;
	exp_ctl_t        ctl_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s7  <= PP_W'(peak_height_q) * PP_W'(m_s6);
			ctl_s7 <= ctl_s6;
		end
	end

	// ---------------- s8: shift by FRACTION_BITS + n, output register ----------------
	logic [SH_W-1:0] sh_amt;
	logic [PP_W-1:0] pp_shift;
	logic [PEAK_W-1:0] curve_s8;
	logic              uflow_s8;

	assign sh_amt   = SH_W'(FRACTION_BITS) + SH_W'(ctl_s7.n);
	assign pp_shift = pp_s7 >> sh_amt;

	always_ff @(posedge clk) begin
		if (adv) begin
			curve_s8 <= ctl_s7.ovf ? '0 : pp_shift[PEAK_W-1:0];
			uflow_s8 <= ctl_s7.ovf;
		end
	end

	assign out_valid   = v_s8;
	assign curve_value = curve_s8;
	assign underflowed = uflow_s8;

`ifndef SYNTHESIS
	// forced underflow always reads zero
	a_uflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && underflowed |-> curve_value == '0)
		else $error("underflowed result is not zero");

	// the curve never rises above its peak
	a_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> curve_value <= peak_height_q)
		else $error("result above peak_height");

	// an accepted request enters stage one
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted request lost at stage one");

	// a held pipeline keeps its items in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && v_s4 |=> v_s4 && $stable(t_s4))
		else $error("stalled stage changed");
`endif

endmodule
